// ----- src/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge, off during reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication");

// next-cycle implication, sampled on the rising clock edge, off during reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ----- src/racbc_pkg.sv -----
package racbc_pkg;

    localparam int KEY_WORDS = 20;
    localparam int ROUNDS    = KEY_WORDS / 2;
    localparam int KEY_USED  = 2 * ROUNDS;
    localparam int RIDX_W    = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

    localparam logic [RIDX_W-1:0] FIRST_ROUND = '0;
    localparam logic [RIDX_W-1:0] LAST_ROUND  = RIDX_W'(ROUNDS - 1);

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_ENC  = 2'd1;
    localparam logic [1:0] CMD_DEC  = 2'd2;
    localparam logic [1:0] CMD_NONE = 2'd3;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_WORD  = 2'd1;
    localparam logic [1:0] KIND_BLOCK = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    localparam int S_DATA_W = 72;
    localparam int S_USER_W = 5;
    localparam int M_DATA_W = 64;
    localparam int M_USER_W = 2;

endpackage

// ----- src/racbc_ram.sv -----
module racbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/rotate_add_chained_block_cipher.sv -----
// Channel | Signals                        | Content
// --------+--------------------------------+----------------------------------------------
// s       | s_tvalid s_tready s_tdata/tuser| command, key index, data, chunk kind, start
// m       | m_tvalid m_tready m_tdata/tuser| result data, result kind
//
// Key load: a transfer is taken whenever the block is idle. Encrypt, and decrypt of a
// block: one round per cycle against the even and odd key banks. Decrypt of a word or
// byte: a forward pass over the odd bank rebuilds the chain sum first. Reset clears
// control and chain state; the key store holds no reset value. A result waits in the
// output register while the next transfer is taken; a finished chunk holds in its
// last step until that register frees.
module rotate_add_chained_block_cipher (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [4:0] key_index, [68:5] data_in, [71:69] zero
    input  logic [racbc_pkg::S_DATA_W-1:0]      s_tdata,
    // [1:0] command, [3:2] chunk_kind, [4] start_of_packet
    input  logic [racbc_pkg::S_USER_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [63:0] result_data
    output logic [racbc_pkg::M_DATA_W-1:0]      m_tdata,
    // [1:0] result_kind
    output logic [racbc_pkg::M_USER_W-1:0]      m_tuser
);

    typedef enum logic [1:0] {S_IDLE, S_SUM, S_RUN, S_DONE} state_t;

    function automatic logic [31:0] rol32(input logic [31:0] v, input logic [4:0] n);
        logic [63:0] w;
        w = {v, v} << n;
        return w[63:32];
    endfunction

    function automatic logic [31:0] ror32(input logic [31:0] v, input logic [4:0] n);
        logic [63:0] w;
        w = {v, v} >> n;
        return w[31:0];
    endfunction

    state_t                        state_reg, state_next;
    logic [racbc_pkg::RIDX_W-1:0]  cnt_reg, cnt_next;
    logic                          dec_reg, dec_next;
    logic [1:0]                    kind_reg, kind_next;
    logic [31:0]                   lo_reg, lo_next;
    logic [31:0]                   hi_reg, hi_next;
    logic [31:0]                   acc_reg, acc_next;
    logic [63:0]                   ct_reg, ct_next;
    logic [31:0]                   chain_lower_reg, chain_lower_next;
    logic [31:0]                   chain_upper_reg, chain_upper_next;
    logic                          out_valid_reg, out_valid_next;
    logic [63:0]                   out_data_reg, out_data_next;
    logic [1:0]                    out_kind_reg, out_kind_next;

    logic [1:0]  cmd_in;
    logic [1:0]  kind_in;
    logic        sop_in;
    logic [4:0]  idx_in;
    logic [63:0] data_in;
    logic [5:0]  idx_ext;
    logic        accept;
    logic        is_chunk;
    logic        key_we;
    logic [31:0] ke;
    logic [31:0] ko;
    logic [31:0] cl;
    logic [31:0] cu;

    logic [31:0] enc_blk_lo;
    logic [31:0] enc_blk_hi;
    logic [31:0] enc_wrd_lo;
    logic [7:0]  enc_byt_lo;
    logic [31:0] acc_add;
    logic [31:0] dec_blk_hi;
    logic [31:0] dec_blk_lo;
    logic [31:0] acc_sub;
    logic [31:0] dec_wrd_lo;
    logic [7:0]  dec_byt_lo;

    assign cmd_in  = s_tuser[1:0];
    assign kind_in = s_tuser[3:2];
    assign sop_in  = s_tuser[4];
    assign idx_in  = s_tdata[4:0];
    assign data_in = s_tdata[68:5];
    assign idx_ext = {1'b0, idx_in};

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign is_chunk = ((cmd_in == racbc_pkg::CMD_ENC) || (cmd_in == racbc_pkg::CMD_DEC))
                      && (kind_in != racbc_pkg::KIND_NONE);
    assign key_we   = accept && (cmd_in == racbc_pkg::CMD_LOAD)
                      && ({1'b0, idx_ext} < 7'(racbc_pkg::KEY_USED));

    racbc_ram #(
        .WIDTH (32),
        .DEPTH (racbc_pkg::ROUNDS)
    ) u_even_keys (
        .clk   (clk),
        .we    (key_we && !idx_in[0]),
        .waddr (idx_ext[racbc_pkg::RIDX_W:1]),
        .wdata (data_in[31:0]),
        .raddr (cnt_next),
        .rdata (ke)
    );

    racbc_ram #(
        .WIDTH (32),
        .DEPTH (racbc_pkg::ROUNDS)
    ) u_odd_keys (
        .clk   (clk),
        .we    (key_we && idx_in[0]),
        .waddr (idx_ext[racbc_pkg::RIDX_W:1]),
        .wdata (data_in[31:0]),
        .raddr (cnt_next),
        .rdata (ko)
    );

    assign cl = sop_in ? 32'd0 : chain_lower_reg;
    assign cu = sop_in ? 32'd0 : chain_upper_reg;

    assign enc_blk_lo = rol32(lo_reg + ke, hi_reg[4:0]);
    assign enc_blk_hi = rol32(hi_reg + ko, enc_blk_lo[4:0]);
    assign enc_wrd_lo = rol32(lo_reg + ke, acc_reg[4:0]);
    assign enc_byt_lo = lo_reg[7:0] + ke[7:0] + acc_reg[7:0];
    assign acc_add    = acc_reg + ko;

    assign dec_blk_hi = ror32(hi_reg, lo_reg[4:0]) - ko;
    assign dec_blk_lo = ror32(lo_reg, dec_blk_hi[4:0]) - ke;
    assign acc_sub    = acc_reg - ko;
    assign dec_wrd_lo = ror32(lo_reg, acc_sub[4:0]) - ke;
    assign dec_byt_lo = lo_reg[7:0] - (ke[7:0] + acc_sub[7:0]);

    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        dec_next         = dec_reg;
        kind_next        = kind_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        acc_next         = acc_reg;
        ct_next          = ct_reg;
        chain_lower_next = chain_lower_reg;
        chain_upper_next = chain_upper_reg;
        out_valid_next   = out_valid_reg && !m_tready;
        out_data_next    = out_data_reg;
        out_kind_next    = out_kind_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept && is_chunk)
                begin
                    chain_lower_next = cl;
                    chain_upper_next = cu;
                    dec_next  = (cmd_in == racbc_pkg::CMD_DEC);
                    kind_next = kind_in;
                    ct_next   = data_in;
                    acc_next  = cu;
                    if (cmd_in == racbc_pkg::CMD_DEC)
                    begin
                        lo_next = data_in[31:0];
                        hi_next = data_in[63:32];
                    end
                    else
                    begin
                        lo_next = data_in[31:0] ^ cl;
                        hi_next = data_in[63:32] ^ cu;
                    end
                    if (kind_in == racbc_pkg::KIND_BYTE)
                    begin
                        lo_next = {24'd0, lo_next[7:0]};
                    end
                    if ((cmd_in == racbc_pkg::CMD_DEC) && (kind_in != racbc_pkg::KIND_BLOCK))
                    begin
                        state_next = S_SUM;
                        cnt_next   = racbc_pkg::FIRST_ROUND;
                    end
                    else if (cmd_in == racbc_pkg::CMD_DEC)
                    begin
                        state_next = S_RUN;
                        cnt_next   = racbc_pkg::LAST_ROUND;
                    end
                    else
                    begin
                        state_next = S_RUN;
                        cnt_next   = racbc_pkg::FIRST_ROUND;
                    end
                end
            end
            S_SUM:
            begin
                acc_next = acc_add;
                if (cnt_reg == racbc_pkg::LAST_ROUND)
                begin
                    chain_upper_next = acc_add;
                    state_next       = S_RUN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_RUN:
            begin
                if (dec_reg)
                begin
                    case (kind_reg)
                        racbc_pkg::KIND_BLOCK:
                        begin
                            lo_next = dec_blk_lo;
                            hi_next = dec_blk_hi;
                        end
                        racbc_pkg::KIND_WORD:
                        begin
                            lo_next  = dec_wrd_lo;
                            acc_next = acc_sub;
                        end
                        default:
                        begin
                            lo_next  = {24'd0, dec_byt_lo};
                            acc_next = acc_sub;
                        end
                    endcase
                    if (cnt_reg == racbc_pkg::FIRST_ROUND)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - 1'b1;
                    end
                end
                else
                begin
                    case (kind_reg)
                        racbc_pkg::KIND_BLOCK:
                        begin
                            lo_next = enc_blk_lo;
                            hi_next = enc_blk_hi;
                        end
                        racbc_pkg::KIND_WORD:
                        begin
                            lo_next  = enc_wrd_lo;
                            acc_next = acc_add;
                        end
                        default:
                        begin
                            lo_next  = {24'd0, enc_byt_lo};
                            acc_next = acc_add;
                        end
                    endcase
                    if (cnt_reg == racbc_pkg::LAST_ROUND)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = kind_reg;
                    state_next     = S_IDLE;
                    if (dec_reg)
                    begin
                        case (kind_reg)
                            racbc_pkg::KIND_BLOCK:
                            begin
                                out_data_next    = {hi_reg ^ chain_upper_reg,
                                                    lo_reg ^ chain_lower_reg};
                                chain_lower_next = ct_reg[31:0];
                                chain_upper_next = ct_reg[63:32];
                            end
                            racbc_pkg::KIND_WORD:
                            begin
                                out_data_next    = {32'd0, lo_reg ^ chain_lower_reg};
                                chain_lower_next = ct_reg[31:0];
                            end
                            default:
                            begin
                                out_data_next    = {56'd0, lo_reg[7:0] ^ chain_lower_reg[7:0]};
                                chain_lower_next = {24'd0, ct_reg[7:0]};
                            end
                        endcase
                    end
                    else
                    begin
                        chain_lower_next = lo_reg;
                        if (kind_reg == racbc_pkg::KIND_BLOCK)
                        begin
                            out_data_next    = {hi_reg, lo_reg};
                            chain_upper_next = hi_reg;
                        end
                        else
                        begin
                            out_data_next    = {32'd0, lo_reg};
                            chain_upper_next = acc_reg;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            dec_reg         <= 1'b0;
            kind_reg        <= '0;
            lo_reg          <= '0;
            hi_reg          <= '0;
            acc_reg         <= '0;
            ct_reg          <= '0;
            out_valid_reg   <= 1'b0;
            out_data_reg    <= '0;
            out_kind_reg    <= '0;
            chain_lower_reg <= 32'd0;
            chain_upper_reg <= 32'd0;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            dec_reg         <= dec_next;
            kind_reg        <= kind_next;
            lo_reg          <= lo_next;
            hi_reg          <= hi_next;
            acc_reg         <= acc_next;
            ct_reg          <= ct_next;
            out_valid_reg   <= out_valid_next;
            out_data_reg    <= out_data_next;
            out_kind_reg    <= out_kind_next;
            chain_lower_reg <= chain_lower_next;
            chain_upper_reg <= chain_upper_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;

endmodule

// ----- src/racbc_checker.sv -----
`include "assert_macros.svh"

module racbc_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [racbc_pkg::S_USER_W-1:0] s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [racbc_pkg::M_DATA_W-1:0] m_tdata,
    input logic [racbc_pkg::M_USER_W-1:0] m_tuser
);

    logic chunk_xfer;
    logic out_stall;
    logic out_word;
    logic out_byte;

    assign chunk_xfer = s_tvalid && s_tready
                        && ((s_tuser[1:0] == racbc_pkg::CMD_ENC)
                            || (s_tuser[1:0] == racbc_pkg::CMD_DEC))
                        && (s_tuser[3:2] != racbc_pkg::KIND_NONE);
    assign out_stall = m_tvalid && !m_tready;
    assign out_word  = m_tvalid && (m_tuser == racbc_pkg::KIND_WORD);
    assign out_byte  = m_tvalid && (m_tuser == racbc_pkg::KIND_BYTE);

    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, $stable({m_tvalid, m_tdata, m_tuser}))
    `ASSERT_NEXT(a_busy_after_chunk, clk, rst_n, chunk_xfer, !s_tready)
    `ASSERT_IMPL(a_kind_valid, clk, rst_n, m_tvalid, m_tuser != racbc_pkg::KIND_NONE)
    `ASSERT_IMPL(a_word_upper_zero, clk, rst_n, out_word, m_tdata[63:32] == 32'd0)
    `ASSERT_IMPL(a_byte_upper_zero, clk, rst_n, out_byte, m_tdata[63:8] == 56'd0)

endmodule

bind rotate_add_chained_block_cipher racbc_checker u_racbc_checker (.*);
